// File: rtl/core/pskmod_pkg.sv
// ----------------------------------------------------------------------------
// pskmod_pkg
// Shared types, constants and the sine magnitude function of the PSK byte
// modulator.
// ----------------------------------------------------------------------------
package pskmod_pkg;

  localparam int SINE_TABLE_BITS_DEF = 10;

  // config register indexes (paddr[2])
  localparam logic REG_PHASE_STEP = 1'b0;
  localparam logic REG_SPS        = 1'b1;

  localparam logic [15:0] SPS_RESET = 16'd800;

  // input word kinds (in_tuser)
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // phase jumps at symbol start, turns * 2^32
  localparam logic [31:0] JUMP_BIT1 = 32'h4000_0000;
  localparam logic [31:0] JUMP_BIT0 = 32'h8000_0000;
  localparam logic [31:0] JUMP_SEP  = 32'hC000_0000;

  localparam logic [3:0] SYM_SEP = 4'd8;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;

  localparam logic [6:0] MAG_FULL = 7'd64;

  // flags that travel with each result word
  typedef struct packed {
    logic valid;
    logic last;
    logic accepted;
  } psk_flags_t;

  // Sine magnitude, 64*sin, for quarter-turn offset f of 2^(tb-2) units.
  // Evaluated at elaboration only.
  function automatic logic [6:0] sine_mag(input longint unsigned f, input int tb);
    longint unsigned quarter;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned r;
    longint unsigned s;
    longint unsigned m;
    quarter = 64'd1 << (tb - 2);
    if (f >= quarter) begin
      return MAG_FULL;
    end
    x  = (f * PI_HALF_Q30) >> (tb - 2);
    x2 = (x * x) >> 30;
    r  = ONE_Q30;
    r  = ONE_Q30 - ((x2 * r) >> 30) / 110;
    r  = ONE_Q30 - ((x2 * r) >> 30) / 72;
    r  = ONE_Q30 - ((x2 * r) >> 30) / 42;
    r  = ONE_Q30 - ((x2 * r) >> 30) / 20;
    r  = ONE_Q30 - ((x2 * r) >> 30) / 6;
    s  = (x * r) >> 30;
    m  = (64 * s) >> 30;
    if (m > 64) begin
      m = 64;
    end
    return m[6:0];
  endfunction

endpackage

// File: rtl/core/psk_byte_modulator.sv
// ----------------------------------------------------------------------------
// psk_byte_modulator
// Differential PSK byte modulator on a numerically controlled carrier.
// ----------------------------------------------------------------------------
// Each byte goes out MSB first as eight symbols plus a separator symbol; at a
// symbol start the carrier phase jumps a quarter turn for a 1, a half turn
// for a 0 and three quarters for the separator. A tick word yields one sample
// 64*sin(phase) (sample_valid=0 and phase held if no byte is queued); a load
// word fills the holding slot and reports whether it was free. Every input
// word gives exactly one result word. The block takes one word per clock
// while its queue has room: the whole state update (buffers, counters, phase
// add) is done in the front part, the sine table read in the back part, and
// a two-entry queue sits between them. A result waits in the queue until
// the output register can take it. Config registers: phase_step at 0x0,
// samples_per_symbol at 0x4 (reset 800, zero acts as one); write them only
// while the block is idle.
// ----------------------------------------------------------------------------
module psk_byte_modulator
  import pskmod_pkg::*;
#(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] action (0 load, 1 tick)
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] sample (signed)
  output logic        out_tlast,  // last_of_byte
  output logic [1:0]  out_tuser,  // [0] sample_valid, [1] load_accepted
  // config port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int QW = SINE_TABLE_BITS + $bits(psk_flags_t);

  // config registers
  logic [31:0] phase_step_r, phase_step_nxt;
  logic [15:0] sps_r, sps_nxt;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    phase_step_nxt = phase_step_r;
    sps_nxt        = sps_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_PHASE_STEP: phase_step_nxt = cfg_pwdata;
        REG_SPS:        sps_nxt        = cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_PHASE_STEP: cfg_prdata = phase_step_r;
      REG_SPS:        cfg_prdata = {16'd0, sps_r};
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
      sps_r        <= SPS_RESET;
    end else begin
      phase_step_r <= phase_step_nxt;
      sps_r        <= sps_nxt;
    end
  end

  // front -> queue -> back
  logic                       in_fire;
  logic [SINE_TABLE_BITS-1:0] push_q;
  psk_flags_t                 push_flags;
  logic                       q_not_full;
  logic                       q_not_empty;
  logic                       q_pop;
  logic [QW-1:0]              q_out;
  psk_flags_t                 q_flags;

  assign in_tready = q_not_full;
  assign in_fire   = in_tvalid && in_tready;

  pskmod_front #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_fire           (in_fire),
    .in_action         (in_tuser[0]),
    .in_byte           (in_tdata),
    .phase_step        (phase_step_r),
    .samples_per_symbol(sps_r),
    .push_q            (push_q),
    .push_flags        (push_flags)
  );

  pskmod_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_fire),
    .push_data({push_q, push_flags}),
    .not_full (q_not_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .pop_data (q_out)
  );

  assign q_flags = q_out[$bits(psk_flags_t)-1:0];

  pskmod_back #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_not_empty(q_not_empty),
    .q_phase    (q_out[QW-1 -: SINE_TABLE_BITS]),
    .q_flags    (q_flags),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// File: rtl/core/pskmod_front.sv
// ----------------------------------------------------------------------------
// pskmod_front
// Takes load and tick words, keeps the byte buffers, symbol counters and the
// carrier phase, and emits the table phase plus result flags per word.
// ----------------------------------------------------------------------------
module pskmod_front
  import pskmod_pkg::*;
#(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  logic                       in_action,
  input  logic [7:0]                 in_byte,
  input  logic [31:0]                phase_step,
  input  logic [15:0]                samples_per_symbol,
  output logic [SINE_TABLE_BITS-1:0] push_q,
  output psk_flags_t                 push_flags
);

  logic [31:0] phase_r, phase_nxt;
  logic [7:0]  act_byte_r, act_byte_nxt;
  logic        act_flag_r, act_flag_nxt;
  logic [7:0]  nxt_byte_r, nxt_byte_nxt;
  logic        nxt_flag_r, nxt_flag_nxt;
  logic [3:0]  sym_r, sym_nxt;
  logic [15:0] samp_r, samp_nxt;

  logic        promote;
  logic        act_eff;
  logic [7:0]  byte_eff;
  logic [3:0]  sym_eff;
  logic [15:0] samp_eff;
  logic        nxt_flag_eff;
  logic [31:0] jump;
  logic [31:0] phase_cur;
  logic        sym_end;
  logic        cur_bit;

  always_comb begin
    phase_nxt    = phase_r;
    act_byte_nxt = act_byte_r;
    act_flag_nxt = act_flag_r;
    nxt_byte_nxt = nxt_byte_r;
    nxt_flag_nxt = nxt_flag_r;
    sym_nxt      = sym_r;
    samp_nxt     = samp_r;
    push_q       = '0;
    push_flags   = '0;

    // holding slot moves up when nothing is in progress
    promote      = !act_flag_r && nxt_flag_r;
    act_eff      = act_flag_r || nxt_flag_r;
    byte_eff     = promote ? nxt_byte_r : act_byte_r;
    sym_eff      = promote ? 4'd0 : sym_r;
    samp_eff     = promote ? 16'd0 : samp_r;
    nxt_flag_eff = promote ? 1'b0 : nxt_flag_r;

    cur_bit = byte_eff[3'd7 - sym_eff[2:0]];
    if (sym_eff >= SYM_SEP) begin
      jump = JUMP_SEP;
    end else if (cur_bit) begin
      jump = JUMP_BIT1;
    end else begin
      jump = JUMP_BIT0;
    end
    phase_cur = (samp_eff == 16'd0) ? phase_r + jump : phase_r;
    // zero length behaves as one sample
    sym_end   = ({1'b0, samp_eff} + 17'd1) >= {1'b0, samples_per_symbol};

    if (in_fire) begin
      if (in_action == ACT_LOAD) begin
        if (!nxt_flag_r) begin
          nxt_byte_nxt        = in_byte;
          nxt_flag_nxt        = 1'b1;
          push_flags.accepted = 1'b1;
        end
      end else if (act_eff) begin
        act_byte_nxt     = byte_eff;
        act_flag_nxt     = 1'b1;
        nxt_flag_nxt     = nxt_flag_eff;
        push_q           = phase_cur[31 -: SINE_TABLE_BITS];
        push_flags.valid = 1'b1;
        phase_nxt        = phase_cur + phase_step;
        if (sym_end) begin
          samp_nxt = 16'd0;
          if (sym_eff >= SYM_SEP) begin
            push_flags.last = 1'b1;
            sym_nxt         = 4'd0;
            act_flag_nxt    = nxt_flag_eff;
            nxt_flag_nxt    = 1'b0;
            if (nxt_flag_eff) begin
              act_byte_nxt = nxt_byte_r;
            end
          end else begin
            sym_nxt = sym_eff + 4'd1;
          end
        end else begin
          sym_nxt  = sym_eff;
          samp_nxt = samp_eff + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      act_byte_r <= '0;
      act_flag_r <= 1'b0;
      nxt_byte_r <= '0;
      nxt_flag_r <= 1'b0;
      sym_r      <= '0;
      samp_r     <= '0;
    end else begin
      phase_r    <= phase_nxt;
      act_byte_r <= act_byte_nxt;
      act_flag_r <= act_flag_nxt;
      nxt_byte_r <= nxt_byte_nxt;
      nxt_flag_r <= nxt_flag_nxt;
      sym_r      <= sym_nxt;
      samp_r     <= samp_nxt;
    end
  end

endmodule

// File: rtl/core/pskmod_queue.sv
// ----------------------------------------------------------------------------
// pskmod_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module pskmod_queue
  import pskmod_pkg::*;
#(
  parameter int WIDTH = SINE_TABLE_BITS_DEF + 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign not_full  = (count_r != 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: rtl/core/pskmod_back.sv
// ----------------------------------------------------------------------------
// pskmod_back
// Sine lookup and sign, into the output register of the result channel.
// ----------------------------------------------------------------------------
module pskmod_back
  import pskmod_pkg::*;
#(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_not_empty,
  input  logic [SINE_TABLE_BITS-1:0] q_phase,
  input  psk_flags_t                 q_flags,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,
  output logic                       out_tlast,
  output logic [1:0]                 out_tuser
);

  localparam int QB      = SINE_TABLE_BITS - 2;
  localparam int QUARTER = 1 << QB;

  // magnitude table over one quarter turn, endpoint included
  logic [6:0] mag_tab [QUARTER+1];

  for (genvar i = 0; i <= QUARTER; i++) begin : g_tab
    assign mag_tab[i] = sine_mag(longint'(i), SINE_TABLE_BITS);
  end

  logic [1:0]    quad;
  logic [QB-1:0] offset;
  logic [QB:0]   f;
  logic [6:0]    mag;
  logic [7:0]    smp;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;
  logic [1:0] out_user_r, out_user_nxt;

  assign quad   = q_phase[SINE_TABLE_BITS-1 -: 2];
  assign offset = q_phase[QB-1:0];
  assign f      = quad[0] ? (QB+1)'(QUARTER) - {1'b0, offset} : {1'b0, offset};
  assign mag    = mag_tab[f];

  always_comb begin
    if (!q_flags.valid) begin
      smp = 8'd0;
    end else if (quad[1]) begin
      smp = 8'd0 - {1'b0, mag};
    end else begin
      smp = {1'b0, mag};
    end
  end

  assign q_pop = q_not_empty && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = smp;
      out_last_nxt  = q_flags.last;
      out_user_nxt  = {q_flags.accepted, q_flags.valid};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule
